// ===== rtl/core/sgrr_pkg.sv =====
`default_nettype none
package sgrr_pkg;

  // Screen and scale defaults for the top level parameters.
  localparam int DEF_SCREEN_WIDTH  = 160;
  localparam int DEF_SCREEN_HEIGHT = 128;
  localparam int DEF_MAX_SCALE     = 8;

  // Field widths of the streams and the register.
  localparam int SCALE_W  = 4;
  localparam int CURSOR_W = 16;
  localparam int CODE_W   = 8;
  localparam int ROW_Y_W  = 7;
  localparam int COL_W    = 8;
  localparam int WIDTH_W  = 6;
  localparam int MASK_W   = 48;
  localparam int IDX_W    = $clog2(MASK_W);

  // Font geometry.
  localparam int FONT_COLS  = 5;
  localparam int FONT_ROWS  = 7;
  localparam int GLYPH_NUM  = 95;
  localparam int FCOL_W     = $clog2(FONT_COLS + 1);
  localparam int FROW_W     = $clog2(FONT_ROWS);
  localparam int GIDX_W     = $clog2(GLYPH_NUM);

  // Command kinds carried in the input tuser.
  localparam logic CMD_CHAR       = 1'b0;
  localparam logic CMD_SET_CURSOR = 1'b1;

  // Character codes with a meaning of their own.
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0] CODE_LAST    = 8'h7E;

  // Register index of the scale register.
  localparam logic REG_GLYPH_SCALE = 1'b0;

  // One cell column handed to the row store.
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     col;
    logic [FONT_ROWS-1:0] bits;
  } col_wr_t;

  // Column font: five columns per glyph, bit r of a column is font row r.
  localparam logic [7:0] GLYPH_ROM [GLYPH_NUM][FONT_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h08,8'h04,8'h08,8'h10,8'h08}
  };

endpackage
`default_nettype wire

// ===== rtl/core/sgrr_row_store.sv =====
`default_nettype none
// Holds the seven expanded font rows of one character cell. Each build step
// writes one cell column into all seven rows; the emit side reads one row.
module sgrr_row_store (
  input  wire logic                                  clk,
  input  wire logic                                  clr,
  input  wire sgrr_pkg::col_wr_t                     wr,
  input  wire logic [sgrr_pkg::FROW_W-1:0]           rd_row,
  output logic      [sgrr_pkg::MASK_W-1:0]           rd_mask
);

  logic [sgrr_pkg::MASK_W-1:0] rows [sgrr_pkg::FONT_ROWS];

  // Clear at the start of a character, then set one column per cycle.
  always_ff @(posedge clk) begin
    if (clr) begin
      for (int k = 0; k < sgrr_pkg::FONT_ROWS; k++) begin
        rows[k] <= '0;
      end
    end else if (wr.en) begin
      for (int k = 0; k < sgrr_pkg::FONT_ROWS; k++) begin
        rows[k][wr.col] <= wr.bits[k];
      end
    end
  end

  // Rows past the font height do not occur; they read as background.
  always_comb begin
    rd_mask = '0;
    for (int k = 0; k < sgrr_pkg::FONT_ROWS; k++) begin
      if (rd_row == sgrr_pkg::FROW_W'(k)) begin
        rd_mask = rows[k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scaled_glyph_row_renderer.sv =====
`default_nettype none
// Character generator with a 16-bit text cursor. An input item either sets the
// cursor or carries a character code; a printable code is drawn from a 5x7 font
// magnified by glyph_scale into a cell of 6*s by 7*s pixels, clipped at the
// right and bottom screen edges, and sent out as one item per screen row with
// its row, first column, clipped width and pixel mask, the last row flagged by
// tlast. Cursor commands, newlines and codes that draw nothing are handled on
// acceptance and leave the block idle. For a drawn character a single column
// counter expands the glyph into the row store one cell column per cycle across
// the clipped cell width, then one row per cycle of the clipped cell height
// leaves through the output register, slower if the sink stalls. Input is not
// taken until the last row has been loaded into the output register.
module scaled_glyph_row_renderer #(
  parameter int SCREEN_WIDTH  = sgrr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = sgrr_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = sgrr_pkg::DEF_MAX_SCALE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // char_code[7:0], set_x[23:8], set_y[39:24]
  input  wire logic [0:0]  s_tuser,  // cmd[0]
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // row_y[6:0], col_start[14:7], row_width[20:15],
                                     // pixel_mask[68:21], zero[71:69]
  output logic             m_tlast,  // last_row
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = sgrr_pkg::SCALE_W;
  localparam int CW = sgrr_pkg::CURSOR_W;
  localparam int IW = sgrr_pkg::IDX_W;
  localparam int WW = sgrr_pkg::WIDTH_W;

  typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_EMIT} state_t;

  state_t state;

  logic [SW-1:0] glyph_scale;
  logic [CW-1:0] cursor_col;
  logic [CW-1:0] cursor_row;

  // Per-character working registers.
  logic [sgrr_pkg::FONT_ROWS-1:0] glyph [sgrr_pkg::FONT_COLS];
  logic [WW-1:0]                  act_w;
  logic [WW-1:0]                  act_h;
  logic [IW-1:0]                  col_idx;
  logic [SW-1:0]                  sub_c;
  logic [sgrr_pkg::FCOL_W-1:0]    src_c;
  logic [WW-1:0]                  em_cnt;
  logic [SW-1:0]                  sub_r;
  logic [sgrr_pkg::FROW_W-1:0]    src_r;
  logic [sgrr_pkg::ROW_Y_W-1:0]   cur_y;
  logic [sgrr_pkg::COL_W-1:0]     cur_x;

  // Output register fields.
  logic [sgrr_pkg::ROW_Y_W-1:0]   o_row_y;
  logic [sgrr_pkg::COL_W-1:0]     o_col;
  logic [WW-1:0]                  o_width;
  logic [sgrr_pkg::MASK_W-1:0]    o_mask;

  // Input fields.
  logic                    in_cmd;
  logic [7:0]              in_code;
  logic [CW-1:0]           in_set_x;
  logic [CW-1:0]           in_set_y;

  assign in_cmd   = s_tuser[0];
  assign in_code  = s_tdata[7:0];
  assign in_set_x = s_tdata[23:8];
  assign in_set_y = s_tdata[39:24];

  // Register port.
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == sgrr_pkg::REG_GLYPH_SCALE);
  assign prdata = {{(32-SW){1'b0}}, glyph_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale <= SW'(1);
    end else if (cfg_wr) begin
      glyph_scale <= (pwdata[SW-1:0] == '0) ? SW'(1) : pwdata[SW-1:0];
    end
  end

  // Cell geometry from the scale: 6*s, 7*s and the newline pitch 8*s.
  logic [SW+2:0] cell_w_full;
  logic [SW+2:0] cell_h_full;
  logic [WW-1:0] cell_w;
  logic [WW-1:0] cell_h;

  assign cell_w_full = {1'b0, glyph_scale, 2'b00} + {2'b00, glyph_scale, 1'b0};
  assign cell_h_full = {glyph_scale, 3'b000} - {3'b000, glyph_scale};
  assign cell_w      = cell_w_full[WW-1:0];
  assign cell_h      = cell_h_full[WW-1:0];

  // Accept-time decode and clipping.
  logic          in_acc;
  logic          printable;
  logic          drawable;
  logic [CW:0]   right_edge;
  logic [CW:0]   bottom_edge;
  logic [CW-1:0] room_w;
  logic [CW-1:0] room_h;
  logic [WW-1:0] clip_w;
  logic [WW-1:0] clip_h;
  logic [sgrr_pkg::GIDX_W-1:0] gidx;
  logic [7:0]    code_off;

  assign s_tready    = (state == ST_IDLE);
  assign in_acc      = s_tvalid && s_tready;
  assign printable   = (in_code >= sgrr_pkg::CODE_FIRST) && (in_code <= sgrr_pkg::CODE_LAST);
  assign drawable    = printable && (glyph_scale <= SW'(MAX_SCALE))
                       && (cursor_col < CW'(SCREEN_WIDTH))
                       && (cursor_row < CW'(SCREEN_HEIGHT));
  assign right_edge  = {1'b0, cursor_col} + (CW+1)'(cell_w);
  assign bottom_edge = {1'b0, cursor_row} + (CW+1)'(cell_h);
  assign room_w      = CW'(SCREEN_WIDTH) - cursor_col;
  assign room_h      = CW'(SCREEN_HEIGHT) - cursor_row;
  assign clip_w      = (right_edge > (CW+1)'(SCREEN_WIDTH)) ? room_w[WW-1:0] : cell_w;
  assign clip_h      = (bottom_edge > (CW+1)'(SCREEN_HEIGHT)) ? room_h[WW-1:0] : cell_h;
  assign code_off    = in_code - sgrr_pkg::CODE_FIRST;
  assign gidx        = code_off[sgrr_pkg::GIDX_W-1:0];

  // Column of the glyph under the build counter; columns past the glyph are blank.
  logic [sgrr_pkg::FONT_ROWS-1:0] src_bits;

  always_comb begin
    src_bits = '0;
    for (int c = 0; c < sgrr_pkg::FONT_COLS; c++) begin
      if (src_c == sgrr_pkg::FCOL_W'(c)) begin
        src_bits = glyph[c];
      end
    end
  end

  sgrr_pkg::col_wr_t col_wr;
  logic [sgrr_pkg::MASK_W-1:0] row_mask;

  assign col_wr.en   = (state == ST_BUILD);
  assign col_wr.col  = col_idx;
  assign col_wr.bits = src_bits;

  sgrr_row_store u_row_store (
    .clk     (clk),
    .clr     (in_acc),
    .wr      (col_wr),
    .rd_row  (src_r),
    .rd_mask (row_mask)
  );

  logic out_free;
  logic last_now;

  assign out_free = !m_tvalid || m_tready;
  assign last_now = (em_cnt == (act_h - WW'(1)));

  // Sequencer: accept, expand the glyph column by column, then emit rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // While emitting, a taken row is replaced by the next one below.
      if (m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_cmd == sgrr_pkg::CMD_SET_CURSOR) begin
              cursor_col <= in_set_x;
              cursor_row <= in_set_y;
            end else if (in_code == sgrr_pkg::CODE_NEWLINE) begin
              cursor_col <= '0;
              cursor_row <= cursor_row + CW'({glyph_scale, 3'b000});
            end else if (drawable) begin
              for (int c = 0; c < sgrr_pkg::FONT_COLS; c++) begin
                glyph[c] <= sgrr_pkg::GLYPH_ROM[gidx][c][sgrr_pkg::FONT_ROWS-1:0];
              end
              act_w      <= clip_w;
              act_h      <= clip_h;
              cur_x      <= cursor_col[sgrr_pkg::COL_W-1:0];
              cur_y      <= cursor_row[sgrr_pkg::ROW_Y_W-1:0];
              col_idx    <= '0;
              sub_c      <= '0;
              src_c      <= '0;
              cursor_col <= cursor_col + CW'(cell_w);
              state      <= ST_BUILD;
            end
          end
        end
        ST_BUILD: begin
          if (col_idx == IW'(act_w - WW'(1))) begin
            em_cnt <= '0;
            sub_r  <= '0;
            src_r  <= '0;
            state  <= ST_EMIT;
          end else begin
            col_idx <= col_idx + IW'(1);
            if (sub_c == glyph_scale - SW'(1)) begin
              sub_c <= '0;
              src_c <= src_c + sgrr_pkg::FCOL_W'(1);
            end else begin
              sub_c <= sub_c + SW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            o_row_y  <= cur_y;
            o_col    <= cur_x;
            o_width  <= act_w;
            o_mask   <= row_mask;
            m_tlast  <= last_now;
            cur_y    <= cur_y + sgrr_pkg::ROW_Y_W'(1);
            em_cnt   <= em_cnt + WW'(1);
            if (sub_r == glyph_scale - SW'(1)) begin
              sub_r <= '0;
              src_r <= src_r + sgrr_pkg::FROW_W'(1);
            end else begin
              sub_r <= sub_r + SW'(1);
            end
            if (last_now) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {3'b000, o_mask, o_width, o_col, o_row_y};

  // The build counter never runs past the clipped width.
  a_build_in_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) |-> (col_idx < IW'(act_w)))
    else $error("build column outside the clipped cell");

  // Emitted rows stay inside the font height and the clipped cell height.
  a_emit_in_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((src_r < sgrr_pkg::FROW_W'(sgrr_pkg::FONT_ROWS)) && (em_cnt < act_h)))
    else $error("emit row outside the glyph cell");

  // An item leaving the block never has an empty width.
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_width != '0))
    else $error("row item with zero width");

  // Loading the last row of a character returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && out_free && last_now) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("sequencer did not finish after the last row");

endmodule
`default_nettype wire
